[design/proximity_group_node_selector_macros.svh]
// ----------------------------------------------------------------------------
// Proximity group node selector assertion macros
// Clocked assertion helpers on clk; PGNS_ASSERT is gated by the active-low reset rst_n, PGNS_ASSERT_ALWAYS is not.
// ----------------------------------------------------------------------------
`ifndef PROXIMITY_GROUP_NODE_SELECTOR_MACROS_SVH
`define PROXIMITY_GROUP_NODE_SELECTOR_MACROS_SVH

`ifndef SYNTHESIS

`define PGNS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define PGNS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PGNS_ASSERT(lbl, prop, msg)

`define PGNS_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

[design/pgns_pkg.sv]
// ----------------------------------------------------------------------------
// Proximity group node selector package
// Widths, request codes and the structs shared by the top level and its cells.
// ----------------------------------------------------------------------------
package pgns_pkg;

  localparam int PTR_W           = 7;
  localparam int NODE_W          = 8;
  localparam int GROUP_W         = 8;
  localparam int FUNC_W          = 2;
  localparam int DEF_MAX_ENTRIES = 64;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_START  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_NEXT   = 2'd2;

  typedef struct packed {
    logic               shift_en;
    logic               rebuild_en;
    logic [NODE_W-1:0]  new_node;
    logic [GROUP_W-1:0] new_group;
    logic [PTR_W-1:0]   count;
  } pgns_ctrl_t;

  typedef struct packed {
    logic [PTR_W-1:0] cur;
    logic [PTR_W-1:0] pre;
    logic [PTR_W-1:0] rs;
  } pgns_rd_t;

  typedef struct packed {
    logic [NODE_W-1:0]  cur_node;
    logic [GROUP_W-1:0] cur_grp;
    logic [PTR_W-1:0]   cur_end;
    logic [NODE_W-1:0]  pre_node;
    logic [GROUP_W-1:0] pre_group;
    logic [PTR_W-1:0]   rs_start;
  } pgns_rdata_t;

endpackage

[design/pgns_cell.sv]
// ----------------------------------------------------------------------------
// Proximity group node selector table cell
// Holds one table entry, shifts it toward the tail on insert, relaxes its
// group bounds from its neighbors and drives its fields onto the read lanes.
// ----------------------------------------------------------------------------
module pgns_cell #(
  parameter int INDEX = 0
) (
  input  logic                          clk,
  input  pgns_pkg::pgns_ctrl_t          ctrl,
  input  pgns_pkg::pgns_rd_t            rd,
  input  logic [pgns_pkg::NODE_W-1:0]   left_node,
  input  logic [pgns_pkg::GROUP_W-1:0]  left_group,
  input  logic [pgns_pkg::PTR_W-1:0]    left_start,
  input  logic                          left_gt,
  input  logic [pgns_pkg::GROUP_W-1:0]  right_group,
  input  logic [pgns_pkg::PTR_W-1:0]    right_end,
  output logic [pgns_pkg::NODE_W-1:0]   node,
  output logic [pgns_pkg::GROUP_W-1:0]  group,
  output logic [pgns_pkg::PTR_W-1:0]    gstart,
  output logic [pgns_pkg::PTR_W-1:0]    gend,
  output logic                          gt,
  output pgns_pkg::pgns_rdata_t         rdata
);

  localparam logic [pgns_pkg::PTR_W-1:0] IDX  = pgns_pkg::PTR_W'(INDEX);
  localparam logic [pgns_pkg::PTR_W-1:0] IDX1 = pgns_pkg::PTR_W'(INDEX + 1);

  logic [pgns_pkg::NODE_W-1:0]  node_r,   node_nxt;
  logic [pgns_pkg::GROUP_W-1:0] group_r,  group_nxt;
  logic [pgns_pkg::PTR_W-1:0]   gstart_r, gstart_nxt;
  logic [pgns_pkg::PTR_W-1:0]   gend_r,   gend_nxt;
  logic                         occupied;

  assign occupied = IDX < ctrl.count;
  assign gt       = occupied && (group_r > ctrl.new_group);

  always_comb begin
    node_nxt   = node_r;
    group_nxt  = group_r;
    gstart_nxt = gstart_r;
    gend_nxt   = gend_r;
    if (ctrl.shift_en) begin
      if ((INDEX != 0) && left_gt) begin
        node_nxt  = left_node;
        group_nxt = left_group;
      end else if (gt || (IDX == ctrl.count)) begin
        node_nxt  = ctrl.new_node;
        group_nxt = ctrl.new_group;
      end
    end
    if (ctrl.rebuild_en && occupied) begin
      if ((INDEX == 0) || (group_r != left_group)) begin
        gstart_nxt = IDX;
      end else begin
        gstart_nxt = left_start;
      end
      if ((IDX1 >= ctrl.count) || (group_r != right_group)) begin
        gend_nxt = IDX1;
      end else begin
        gend_nxt = right_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    node_r   <= node_nxt;
    group_r  <= group_nxt;
    gstart_r <= gstart_nxt;
    gend_r   <= gend_nxt;
  end

  assign node   = node_r;
  assign group  = group_r;
  assign gstart = gstart_r;
  assign gend   = gend_r;

  always_comb begin
    rdata = '0;
    if (rd.cur == IDX) begin
      rdata.cur_node = node_r;
      rdata.cur_grp  = group_r;
      rdata.cur_end  = gend_r;
    end
    if (rd.pre == IDX) begin
      rdata.pre_node  = node_r;
      rdata.pre_group = group_r;
    end
    if (rd.rs == IDX) begin
      rdata.rs_start = gstart_r;
    end
  end

endmodule

[design/proximity_group_node_selector.sv]
// ----------------------------------------------------------------------------
// Proximity group node selector
// Sorted node table by proximity group with a pre-scan / round-robin cursor.
// ----------------------------------------------------------------------------
// Usage: one request per input transfer (in_func, in_new_node_id,
// in_new_group); every request yields exactly one output transfer
// (out_chosen_node, out_status), in request order.
// Get next, start, unused codes and a refused insert pass through a read step,
// which reads the table through the per-cell select lanes into a register,
// and an exec step, which updates the cursor and loads the output.
// A new request is taken only once the previous one has loaded its output.
// An accepted insert shifts the cell row in the exec step, relaxes the group
// start and end bounds cell to cell in the rebuild step, then loads the
// output in a done step.
// Reset empties the table and clears the cursor and pre-scan; entry contents
// are not cleared.
// While out_stall holds, the output register holds its transfer; one further
// request may be taken and waits in its last step until the output drains.
// ----------------------------------------------------------------------------
`include "proximity_group_node_selector_macros.svh"

module proximity_group_node_selector #(
  parameter int MAX_ENTRIES = pgns_pkg::DEF_MAX_ENTRIES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pgns_pkg::FUNC_W-1:0]   in_func,
  input  logic [pgns_pkg::NODE_W-1:0]   in_new_node_id,
  input  logic [pgns_pkg::GROUP_W-1:0]  in_new_group,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pgns_pkg::NODE_W-1:0]   out_chosen_node,
  output logic                          out_status
);

  localparam int PW = pgns_pkg::PTR_W;
  localparam logic [PW-1:0] MAX_C  = PW'(MAX_ENTRIES);
  localparam logic [PW-1:0] RB_TOP = PW'(MAX_ENTRIES - 1);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_READ    = 3'd1;
  localparam logic [2:0] ST_EXEC    = 3'd2;
  localparam logic [2:0] ST_REBUILD = 3'd3;
  localparam logic [2:0] ST_DONE    = 3'd4;

  logic [2:0]                    state_r, state_nxt;
  logic [pgns_pkg::FUNC_W-1:0]   func_r;
  logic [pgns_pkg::NODE_W-1:0]   node_in_r;
  logic [pgns_pkg::GROUP_W-1:0]  group_in_r;
  logic [PW-1:0]                 count_r, count_nxt;
  logic [PW-1:0]                 cursor_r, cursor_nxt;
  logic [PW-1:0]                 round_r, round_nxt;
  logic [PW-1:0]                 pre_r, pre_nxt;
  logic                          pre_act_r, pre_act_nxt;
  logic [PW-1:0]                 rb_cnt_r, rb_cnt_nxt;
  pgns_pkg::pgns_rdata_t         rdata_r;
  pgns_pkg::pgns_rdata_t         rdata_all;
  logic                          out_valid_r, out_valid_nxt;
  logic [pgns_pkg::NODE_W-1:0]   out_node_r, out_node_nxt;
  logic                          out_status_r, out_status_nxt;

  logic                          in_xfer;
  logic                          can_out;
  logic                          full;
  logic                          load_out;
  logic [PW-1:0]                 nxt_pos;
  logic [PW-1:0]                 cp;

  pgns_pkg::pgns_ctrl_t          ctrl;
  pgns_pkg::pgns_rd_t            rd;

  logic [pgns_pkg::NODE_W-1:0]   cell_node   [MAX_ENTRIES];
  logic [pgns_pkg::GROUP_W-1:0]  cell_group  [MAX_ENTRIES];
  logic [PW-1:0]                 cell_gstart [MAX_ENTRIES];
  logic [PW-1:0]                 cell_gend   [MAX_ENTRIES];
  logic                          cell_gt     [MAX_ENTRIES];
  pgns_pkg::pgns_rdata_t         cell_rdata  [MAX_ENTRIES];

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign can_out  = !out_valid_r || !out_stall;
  assign full     = (count_r >= MAX_C);

  assign ctrl.shift_en   = (state_r == ST_EXEC) && (func_r == pgns_pkg::FUNC_INSERT) && !full;
  assign ctrl.rebuild_en = (state_r == ST_REBUILD);
  assign ctrl.new_node   = node_in_r;
  assign ctrl.new_group  = group_in_r;
  assign ctrl.count      = count_r;

  assign rd.cur = cursor_r;
  assign rd.pre = pre_r;
  assign rd.rs  = round_r;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [pgns_pkg::NODE_W-1:0]  l_node;
    logic [pgns_pkg::GROUP_W-1:0] l_group;
    logic [PW-1:0]                l_start;
    logic                         l_gt;
    logic [pgns_pkg::GROUP_W-1:0] r_group;
    logic [PW-1:0]                r_end;

    if (i == 0) begin : g_first
      assign l_node  = '0;
      assign l_group = '0;
      assign l_start = '0;
      assign l_gt    = 1'b0;
    end else begin : g_mid
      assign l_node  = cell_node[i-1];
      assign l_group = cell_group[i-1];
      assign l_start = cell_gstart[i-1];
      assign l_gt    = cell_gt[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_last
      assign r_group = '0;
      assign r_end   = '0;
    end else begin : g_body
      assign r_group = cell_group[i+1];
      assign r_end   = cell_gend[i+1];
    end

    pgns_cell #(
      .INDEX (i)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .rd          (rd),
      .left_node   (l_node),
      .left_group  (l_group),
      .left_start  (l_start),
      .left_gt     (l_gt),
      .right_group (r_group),
      .right_end   (r_end),
      .node        (cell_node[i]),
      .group       (cell_group[i]),
      .gstart      (cell_gstart[i]),
      .gend        (cell_gend[i]),
      .gt          (cell_gt[i]),
      .rdata       (cell_rdata[i])
    );
  end

  always_comb begin
    rdata_all = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      rdata_all = rdata_all | cell_rdata[i];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    cursor_nxt     = cursor_r;
    round_nxt      = round_r;
    pre_nxt        = pre_r;
    pre_act_nxt    = pre_act_r;
    rb_cnt_nxt     = rb_cnt_r;
    load_out       = 1'b0;
    out_node_nxt   = out_node_r;
    out_status_nxt = out_status_r;
    nxt_pos        = cursor_r + PW'(1);
    cp             = pre_act_r ? pre_r : cursor_r;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (ctrl.shift_en) begin
          count_nxt  = count_r + PW'(1);
          rb_cnt_nxt = RB_TOP;
          state_nxt  = ST_REBUILD;
        end else if (can_out) begin
          load_out       = 1'b1;
          out_node_nxt   = '0;
          out_status_nxt = 1'b0;
          state_nxt      = ST_IDLE;
          case (func_r)
            pgns_pkg::FUNC_INSERT: begin
              out_status_nxt = 1'b1;
            end
            pgns_pkg::FUNC_START: begin
              if (cp >= count_r) begin
                cp = '0;
              end
              cursor_nxt  = cp;
              round_nxt   = cp;
              pre_nxt     = '0;
              pre_act_nxt = 1'b1;
            end
            pgns_pkg::FUNC_NEXT: begin
              if (cursor_r < count_r) begin
                if (pre_act_r && (pre_r < count_r) &&
                    (rdata_r.pre_group != rdata_r.cur_grp)) begin
                  out_node_nxt = rdata_r.pre_node;
                  pre_nxt      = pre_r + PW'(1);
                end else begin
                  pre_act_nxt = 1'b0;
                  if (nxt_pos == rdata_r.cur_end) begin
                    nxt_pos = rdata_r.rs_start;
                  end
                  if (nxt_pos != round_r) begin
                    cursor_nxt = nxt_pos;
                  end else begin
                    cursor_nxt = rdata_r.cur_end;
                    round_nxt  = rdata_r.cur_end;
                  end
                  out_node_nxt = rdata_r.cur_node;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_REBUILD: begin
        rb_cnt_nxt = rb_cnt_r - PW'(1);
        if (rb_cnt_r == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (can_out) begin
          load_out       = 1'b1;
          out_node_nxt   = '0;
          out_status_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cursor_r    <= '0;
      round_r     <= '0;
      pre_r       <= '0;
      pre_act_r   <= 1'b0;
      rb_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cursor_r    <= cursor_nxt;
      round_r     <= round_nxt;
      pre_r       <= pre_nxt;
      pre_act_r   <= pre_act_nxt;
      rb_cnt_r    <= rb_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      func_r     <= in_func;
      node_in_r  <= in_new_node_id;
      group_in_r <= in_new_group;
    end
    if (state_r == ST_READ) begin
      rdata_r <= rdata_all;
    end
    out_node_r   <= out_node_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_chosen_node = out_node_r;
  assign out_status      = out_status_r;

  `PGNS_ASSERT(a_count_bound, count_r <= MAX_C, "entry count beyond table size")
  `PGNS_ASSERT(a_accept_to_read, in_xfer |=> (state_r == ST_READ), "transfer did not start read")
  `PGNS_ASSERT(a_count_on_shift, count_r != $past(count_r) |-> $past(ctrl.shift_en || !rst_n), "count moved")
  `PGNS_ASSERT(a_full_status, (out_valid_r && out_status_r) |-> full, "full status with room in table")

endmodule
